FILE: design/assert_macros.svh
// Assertion macros for the RTMP chunk header parser RTL (used by rcp_parse).
// Each expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define RCP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define RCP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rcp_pkg.sv
// Shared types and constants for the RTMP chunk header parser.
// No dependencies; used by the parser modules.
package rcp_pkg;

	// chunk header formats (bits 7..6 of the first byte)
	localparam logic [1:0] FMT_FULL      = 2'd0;
	localparam logic [1:0] FMT_NO_STREAM = 2'd1;
	localparam logic [1:0] FMT_TIME_ONLY = 2'd2;
	localparam logic [1:0] FMT_NONE      = 2'd3;

	localparam logic [5:0]  ID_MASK      = 6'h3F;
	localparam logic [16:0] ID_BASE      = 17'd64;
	localparam logic [31:0] TIME_ESCAPE  = 32'h00FF_FFFF;
	localparam logic [4:0]  MAX_HDR_LEN  = 5'd18;

	typedef struct packed {
		logic [1:0]  chunk_format;
		logic [16:0] chunk_stream;
		logic [31:0] time_stamp;
		logic [23:0] body_length;
		logic [7:0]  content_kind;
		logic [31:0] message_stream;
		logic        has_extended;
		logic [4:0]  header_length;
	} rcp_hdr_t;

	// parser to output register: header completes on the current word
	typedef struct packed {
		logic     fire;
		rcp_hdr_t hdr;
	} rcp_done_t;

endpackage

FILE: design/rcp_byte_if.sv
// Header byte channel: valid/ready handshake with one byte of payload.
// Standalone; no package needed.
interface rcp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;

	modport source (output valid, output header_byte, input ready);
	modport sink   (input valid, input header_byte, output ready);
endinterface

FILE: design/rcp_hdr_if.sv
// Decoded header channel: valid/ready handshake with the header fields.
// Standalone; no package needed.
interface rcp_hdr_if;
	logic        valid;
	logic        ready;
	logic [1:0]  chunk_format;
	logic [16:0] chunk_stream;
	logic [31:0] time_stamp;
	logic [23:0] body_length;
	logic [7:0]  content_kind;
	logic [31:0] message_stream;
	logic        has_extended;
	logic [4:0]  header_length;

	modport source (output valid, output chunk_format, output chunk_stream,
		output time_stamp, output body_length, output content_kind,
		output message_stream, output has_extended, output header_length,
		input ready);
	modport sink (input valid, input chunk_format, input chunk_stream,
		input time_stamp, input body_length, input content_kind,
		input message_stream, input has_extended, input header_length,
		output ready);
endinterface

FILE: design/rcp_parse.sv
// Parse state machine and held header fields; decodes one word per step.
// Depends on rcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcp_parse
	import rcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] hdr_byte,
	output rcp_done_t  done
);

	typedef enum logic [6:0] {
		PH_FIRST = 7'b0000001,
		PH_ID    = 7'b0000010,
		PH_TIME  = 7'b0000100,
		PH_SIZE  = 7'b0001000,
		PH_KIND  = 7'b0010000,
		PH_MSID  = 7'b0100000,
		PH_EXT   = 7'b1000000
	} rcp_phase_t;

	// where the search for the next needed field starts
	localparam logic [1:0] START_TIME = 2'd0;
	localparam logic [1:0] START_SIZE = 2'd1;
	localparam logic [1:0] START_MSID = 2'd2;
	localparam logic [1:0] START_EXT  = 2'd3;

	typedef struct packed {
		logic       fin;
		rcp_phase_t phase;
	} rcp_goto_t;

	function automatic rcp_goto_t goto_from(input logic [1:0] start,
		input logic [1:0] fmt, input logic [31:0] tm);
		rcp_goto_t g;
		g.fin   = 1'b0;
		g.phase = PH_FIRST;
		priority if (start == START_TIME && fmt != FMT_NONE) begin
			g.phase = PH_TIME;
		end else if (start <= START_SIZE && fmt <= FMT_NO_STREAM) begin
			g.phase = PH_SIZE;
		end else if (start <= START_MSID && fmt == FMT_FULL) begin
			g.phase = PH_MSID;
		end else if (tm == TIME_ESCAPE) begin
			g.phase = PH_EXT;
		end else begin
			g.fin = 1'b1;
		end
		return g;
	endfunction

	rcp_phase_t  phase_q, n_phase;
	logic [1:0]  idx_q, n_idx;
	logic [4:0]  total_q, n_total, total_inc;
	logic [1:0]  fmt_q, n_fmt;
	logic [16:0] sid_q, n_sid;
	logic [31:0] time_q, n_time;
	logic [23:0] size_q, n_size;
	logic [7:0]  kind_q, n_kind;
	logic [31:0] ms_q, n_ms;
	logic        go;
	logic        ext_fin;
	logic [1:0]  start;
	rcp_goto_t   g;

	always_comb begin
		total_inc = total_q + 5'd1;
		n_phase   = phase_q;
		n_idx     = idx_q;
		n_total   = total_inc;
		n_fmt     = fmt_q;
		n_sid     = sid_q;
		n_time    = time_q;
		n_size    = size_q;
		n_kind    = kind_q;
		n_ms      = ms_q;
		go        = 1'b0;
		ext_fin   = 1'b0;
		start     = START_TIME;

		unique case (phase_q)
			PH_FIRST: begin
				n_fmt = hdr_byte[7:6];
				n_sid = {11'd0, hdr_byte[5:0] & ID_MASK};
				if (hdr_byte[5:1] == 5'd0) begin
					// id 0 or 1: extra id bytes follow, index marks how many
					n_idx   = {1'b0, hdr_byte[0]};
					n_phase = PH_ID;
				end else begin
					go = 1'b1;
				end
			end
			PH_ID: begin
				if (total_inc == 5'd2) begin
					n_sid = {9'd0, hdr_byte} + ID_BASE;
					go    = (idx_q != 2'd1);
				end else begin
					n_sid = sid_q + {1'b0, hdr_byte, 8'd0};
					go    = 1'b1;
				end
			end
			PH_TIME: begin
				n_time = {8'd0, (idx_q == 2'd0) ? 16'd0 : time_q[15:0], hdr_byte};
				start  = START_SIZE;
				if (idx_q < 2'd2) begin
					n_idx = idx_q + 2'd1;
				end else begin
					go = 1'b1;
				end
			end
			PH_SIZE: begin
				n_size = {(idx_q == 2'd0) ? 16'd0 : size_q[15:0], hdr_byte};
				if (idx_q < 2'd2) begin
					n_idx = idx_q + 2'd1;
				end else begin
					n_idx   = 2'd0;
					n_phase = PH_KIND;
				end
			end
			PH_KIND: begin
				n_kind = hdr_byte;
				start  = START_MSID;
				go     = 1'b1;
			end
			PH_MSID: begin
				// little endian: byte index picks the lane
				n_ms  = (idx_q == 2'd0) ? {24'd0, hdr_byte}
					: (ms_q | ({24'd0, hdr_byte} << {idx_q, 3'b000}));
				start = START_EXT;
				if (idx_q < 2'd3) begin
					n_idx = idx_q + 2'd1;
				end else begin
					go = 1'b1;
				end
			end
			PH_EXT: begin
				n_time = {(idx_q == 2'd0) ? 24'd0 : time_q[23:0], hdr_byte};
				if (idx_q < 2'd3) begin
					n_idx = idx_q + 2'd1;
				end else begin
					ext_fin = 1'b1;
				end
			end
			default: begin
				// bad phase code: restart
				n_phase = PH_FIRST;
				n_total = 5'd0;
				n_idx   = 2'd0;
			end
		endcase

		g = goto_from(start, n_fmt, n_time);
		done.fire = ext_fin | (go & g.fin);
		if (done.fire) begin
			n_phase = PH_FIRST;
			n_total = 5'd0;
			n_idx   = 2'd0;
		end else if (go) begin
			n_phase = g.phase;
			n_idx   = 2'd0;
		end

		done.hdr.chunk_format   = n_fmt;
		done.hdr.chunk_stream   = n_sid;
		done.hdr.time_stamp     = n_time;
		done.hdr.body_length    = n_size;
		done.hdr.content_kind   = n_kind;
		done.hdr.message_stream = n_ms;
		done.hdr.has_extended   = ext_fin;
		done.hdr.header_length  = total_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			idx_q   <= 2'd0;
			total_q <= 5'd0;
			fmt_q   <= 2'd0;
			sid_q   <= 17'd0;
			time_q  <= 32'd0;
			size_q  <= 24'd0;
			kind_q  <= 8'd0;
			ms_q    <= 32'd0;
		end else if (step) begin
			phase_q <= n_phase;
			idx_q   <= n_idx;
			total_q <= n_total;
			fmt_q   <= n_fmt;
			sid_q   <= n_sid;
			time_q  <= n_time;
			size_q  <= n_size;
			kind_q  <= n_kind;
			ms_q    <= n_ms;
		end
	end

	`RCP_ASSERT_IMP(a_len_range, done.fire, done.hdr.header_length >= 5'd1 && done.hdr.header_length <= MAX_HDR_LEN, "header length out of range")
	`RCP_ASSERT_IMP(a_full_len, done.fire && done.hdr.chunk_format == FMT_FULL, done.hdr.header_length >= 5'd12, "full header too short")
	`RCP_ASSERT_NXT(a_first_count, step && phase_q == PH_FIRST, total_q == 5'd1 || total_q == 5'd0, "byte count wrong after first byte")

endmodule

FILE: design/rcp_out_reg.sv
// Result register for decoded headers; drives the output channel.
// Depends on rcp_pkg and rcp_hdr_if.
module rcp_out_reg
	import rcp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  rcp_hdr_t data_in,
	output logic     free,
	rcp_hdr_if.source hdr
);

	logic     valid_q;
	rcp_hdr_t data_q;

	assign free = !valid_q || hdr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (hdr.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_in;
		end
	end

	assign hdr.valid          = valid_q;
	assign hdr.chunk_format   = data_q.chunk_format;
	assign hdr.chunk_stream   = data_q.chunk_stream;
	assign hdr.time_stamp     = data_q.time_stamp;
	assign hdr.body_length    = data_q.body_length;
	assign hdr.content_kind   = data_q.content_kind;
	assign hdr.message_stream = data_q.message_stream;
	assign hdr.has_extended   = data_q.has_extended;
	assign hdr.header_length  = data_q.header_length;

endmodule

FILE: design/rtmp_chunk_header_parser.sv
// RTMP chunk header parser, top level. An accepted header word (the last
// byte of a header) reaches hdr_info via the input and result registers.
// Throughput: one word per cycle; set by the single parse step between
// the input register and the result register, stalled only by hdr_info.
// Reset (arst_n low, async): parser waits for a first byte, fields are 0.
// Depends on rcp_pkg, rcp_byte_if, rcp_hdr_if, rcp_parse, rcp_out_reg.
module rtmp_chunk_header_parser
	import rcp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	rcp_byte_if.sink   hdr_bytes,
	rcp_hdr_if.source  hdr_info
);

	// input stage: one header word waiting for the parser
	logic       valid_s1;
	logic [7:0] byte_s1;

	rcp_done_t done;
	logic      out_free;
	logic      advance;

	// The word in s1 moves on unless it completes a header while the
	// result register is still full and not being drained.
	assign advance         = valid_s1 && (!done.fire || out_free);
	assign hdr_bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr_bytes.valid && hdr_bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_bytes.valid && hdr_bytes.ready) begin
			byte_s1 <= hdr_bytes.header_byte;
		end
	end

	// field decode and held header state
	rcp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.hdr_byte (byte_s1),
		.done     (done)
	);

	// result register, loaded when a header completes
	rcp_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && done.fire),
		.data_in (done.hdr),
		.free    (out_free),
		.hdr     (hdr_info)
	);

endmodule
